### design/spcb_pkg.sv
// Shared types and constants for the servo pulse channel bank.
// Holds the request and response beat layouts, item kinds and register indexes.
// Depends on nothing; every module of the bank imports it.
`default_nettype none

package spcb_pkg;

   // Field widths fixed by the beat layout.
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned CHAN_W  = 4;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Item kinds carried in the request beat.
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_TICKS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_PULSE       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_PULSE       = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_CHANNELS = 2'd3;

   // Register values after reset (50 Hz frame, 1 ms to 2 ms pulses, all servos on).
   localparam logic [TICK_W-1:0]  PERIOD_TICKS_RESET    = 16'd19999;
   localparam logic [TICK_W-1:0]  MIN_PULSE_RESET       = 16'd1000;
   localparam logic [TICK_W-1:0]  MAX_PULSE_RESET       = 16'd2000;
   localparam logic [COUNT_W-1:0] ACTIVE_CHANNELS_RESET = 4'd8;

   // Request beat.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAN_W-1:0] channel;
      logic [TICK_W-1:0] pulse;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic               ok;
      logic [TICK_W-1:0]  read_value;
      logic [LEVEL_W-1:0] pwm_levels;
      logic               period_start;
   } rsp_type;

endpackage

`default_nettype wire

### design/servo_pwm_channel_bank_core.sv
// Servo pulse channel bank: shared frame counter, pulse store and level compare.
// Depends on spcb_pkg for the beat layouts, item kinds and register indexes.
`default_nettype none

// The bank takes one request beat per clock and returns exactly one response
// beat for it: the beat is held in an input register, processed by one pass of
// logic (counter step, pulse store update and the parallel compare of every
// channel against the counter) and captured in the response register. Back to
// back beats flow at one per cycle; the only stall comes from rsp_ready, which
// the input register absorbs. A tick beat advances the frame counter,
// a write beat stores a pulse width that is zero or inside [min_pulse,
// max_pulse], and a read beat returns the stored
// width. Every response carries the channel levels after the beat took effect.
// Configuration writes are taken at any time but are meant for an idle bank.
module servo_pwm_channel_bank_core
   import spcb_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   // Response channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   // Configuration write port.
   input  wire logic                  csr_write,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Channels that own a bit of the level vector.
   localparam int unsigned LEVEL_CHANNELS = (NUM_CHANNELS < LEVEL_W) ? NUM_CHANNELS : LEVEL_W;
   // One bit wider than a channel number so that a bank of sixteen still fits.
   localparam logic [CHAN_W:0] LAST_CHANNEL = (CHAN_W+1)'(NUM_CHANNELS);

   // Configuration registers.
   logic [TICK_W-1:0]  period_ticks_ff;
   logic [TICK_W-1:0]  min_pulse_ff;
   logic [TICK_W-1:0]  max_pulse_ff;
   logic [COUNT_W-1:0] active_channels_ff;

   // Frame counter and pulse store.
   logic [TICK_W-1:0] counter_ff, counter_in;
   logic [TICK_W-1:0] pulse_ff [NUM_CHANNELS];
   logic [TICK_W-1:0] pulse_in [NUM_CHANNELS];

   // Input and response registers.
   logic    in_valid_ff;
   req_type in_beat_ff;
   logic    out_valid_ff;
   rsp_type out_beat_ff, out_beat_in;

   logic advance;
   logic valid_chan;
   logic pulse_good;
   logic write_ok;
   logic [TICK_W-1:0] read_data;

   // Handshake: the pass runs when the response register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_beat_ff;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff    <= PERIOD_TICKS_RESET;
         min_pulse_ff       <= MIN_PULSE_RESET;
         max_pulse_ff       <= MAX_PULSE_RESET;
         active_channels_ff <= ACTIVE_CHANNELS_RESET;
      end else if (csr_write) begin
         case (csr_addr)
            CSR_PERIOD_TICKS:    period_ticks_ff    <= csr_data;
            CSR_MIN_PULSE:       min_pulse_ff       <= csr_data;
            CSR_MAX_PULSE:       max_pulse_ff       <= csr_data;
            CSR_ACTIVE_CHANNELS: active_channels_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: captures a request beat whenever there is room.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_beat_ff <= req_payload;
      end
   end

   // Channel check and write acceptance window.
   assign valid_chan = (in_beat_ff.channel != '0) &&
                       ({1'b0, in_beat_ff.channel} <= LAST_CHANNEL);
   assign pulse_good = (in_beat_ff.pulse == '0) ||
                       ((in_beat_ff.pulse >= min_pulse_ff) && (in_beat_ff.pulse <= max_pulse_ff));
   assign write_ok   = (in_beat_ff.kind == KIND_WRITE) && valid_chan && pulse_good;

   // Counter step: wrap to zero at or past the last tick of the frame.
   always_comb begin
      counter_in = counter_ff;
      if (in_beat_ff.kind == KIND_TICK) begin
         if (counter_ff >= period_ticks_ff) begin
            counter_in = '0;
         end else begin
            counter_in = counter_ff + TICK_W'(1);
         end
      end
   end

   // Store update and read select, one slot per channel.
   always_comb begin
      read_data = '0;
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
         pulse_in[i] = pulse_ff[i];
         if (write_ok && (in_beat_ff.channel == CHAN_W'(i + 1))) begin
            pulse_in[i] = in_beat_ff.pulse;
         end
         if (in_beat_ff.channel == CHAN_W'(i + 1)) begin
            read_data = pulse_ff[i];
         end
      end
   end

   // Response: levels come from the counter and store after the beat.
   always_comb begin
      out_beat_in = '0;
      case (in_beat_ff.kind)
         KIND_TICK: begin
            out_beat_in.ok           = 1'b1;
            out_beat_in.period_start = (counter_ff >= period_ticks_ff);
         end
         KIND_WRITE: begin
            out_beat_in.ok = write_ok;
         end
         KIND_READ: begin
            out_beat_in.ok         = valid_chan;
            out_beat_in.read_value = valid_chan ? read_data : '0;
         end
         default: ;
      endcase
      for (int unsigned i = 0; i < LEVEL_CHANNELS; i++) begin
         // Groups: channels 1-4 need a nonzero count, 5-6 need five, the rest seven.
         logic enabled;
         enabled = 1'b0;
         if (active_channels_ff != '0) begin
            if (i < 4) begin
               enabled = 1'b1;
            end else if (i < 6) begin
               enabled = (active_channels_ff >= COUNT_W'(5));
            end else begin
               enabled = (active_channels_ff >= COUNT_W'(7));
            end
         end
         out_beat_in.pwm_levels[i] = enabled && (counter_in < pulse_in[i]);
      end
   end

   // State registers advance once per processed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
            pulse_ff[i] <= '0;
         end
      end else if (advance) begin
         counter_ff <= counter_in;
         for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
            pulse_ff[i] <= pulse_in[i];
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_beat_ff <= out_beat_in;
      end
   end

endmodule

`default_nettype wire

### tb/sv/servo_pwm_channel_bank_core_tb.sv
// Self-checking testbench for the servo pulse channel bank core.
// Drives request beats, predicts each response beat and checks it in order.
// Depends on spcb_pkg and servo_pwm_channel_bank_core.
`default_nettype none

module servo_pwm_channel_bank_core_tb;
   import spcb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_CH       = 8;
   localparam int unsigned BANK_LATENCY = 3;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned BLOCKS       = 5;
   localparam int unsigned BLOCK_ITEMS  = 93;

   // The request layout leaves this kind code unused.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic                  csr_write;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_data;

   // Shadow copy of the bank: registers, frame counter and pulse widths.
   logic [TICK_W-1:0]  cfg_period;
   logic [TICK_W-1:0]  cfg_min_pulse;
   logic [TICK_W-1:0]  cfg_max_pulse;
   logic [COUNT_W-1:0] cfg_servo_count;
   logic [TICK_W-1:0]  frame_count;
   logic [TICK_W-1:0]  pulse_mem [NUM_CH];

   rsp_type     servo_rsp_q [$];
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned hold_request      = 0;
   int unsigned error_count       = 0;
   int unsigned cycle_count       = 0;

   servo_pwm_channel_bank_core #(
      .NUM_CHANNELS(NUM_CH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_addr    (csr_addr),
      .csr_data    (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Channel groups: 1-4 with any nonzero count, 5-6 from five servos, 7 and up from seven.
   function automatic logic servo_enabled(int unsigned ch);
      if (cfg_servo_count == '0) return 1'b0;
      if (ch <= 4) return 1'b1;
      if (ch <= 6) return cfg_servo_count >= 5;
      return cfg_servo_count >= 7;
   endfunction

   // Applies one request beat to the shadow bank and returns its response beat.
   function automatic rsp_type servo_bank_step(req_type item);
      rsp_type r;
      logic    chan_ok;
      r = '0;
      chan_ok = item.channel >= 1 && item.channel <= NUM_CH;
      case (item.kind)
         KIND_TICK: begin
            if (frame_count >= cfg_period) begin
               frame_count = '0;
               r.period_start = 1'b1;
            end else begin
               frame_count = frame_count + 1'b1;
            end
            r.ok = 1'b1;
         end
         KIND_WRITE: begin
            if (chan_ok && (item.pulse == '0 ||
                  (item.pulse >= cfg_min_pulse && item.pulse <= cfg_max_pulse))) begin
               pulse_mem[item.channel - 1'b1] = item.pulse;
               r.ok = 1'b1;
            end
         end
         KIND_READ: begin
            if (chan_ok) begin
               r.read_value = pulse_mem[item.channel - 1'b1];
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      // Levels are taken after the beat has taken effect.
      for (int unsigned ch = 1; ch <= NUM_CH && ch <= LEVEL_W; ch++) begin
         if (servo_enabled(ch) && frame_count < pulse_mem[ch - 1])
            r.pwm_levels[ch - 1] = 1'b1;
      end
      return r;
   endfunction

   function automatic req_type make_item(logic [KIND_W-1:0] kind, int unsigned ch,
                                         int unsigned pulse);
      req_type it;
      it.kind    = kind;
      it.channel = CHAN_W'(ch);
      it.pulse   = TICK_W'(pulse);
      return it;
   endfunction

   // Mostly well-formed traffic with legal pulses, plus some raw noise.
   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      pick       = $urandom_range(99);
      it.kind    = KIND_TICK;
      it.channel = CHAN_W'($urandom_range(NUM_CH, 1));
      it.pulse   = TICK_W'($urandom());
      if (pick < 45) begin
         it.kind = KIND_TICK;
      end else if (pick < 70) begin
         it.kind = KIND_WRITE;
         if ($urandom_range(7) == 0)
            it.pulse = '0;
         else
            it.pulse = TICK_W'($urandom_range(cfg_max_pulse, cfg_min_pulse));
      end else if (pick < 88) begin
         it.kind = KIND_READ;
      end else begin
         it.kind    = KIND_W'($urandom_range(3));
         it.channel = CHAN_W'($urandom());
      end
      return it;
   endfunction

   // Sends one request beat, with a random gap first, and records its response.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      servo_rsp_q.push_back(servo_bank_step(item));
   endtask

   // Stops offering beats and waits until every response has come back.
   task automatic drain_bank();
      req_valid <= 1'b0;
      while (servo_rsp_q.size() != 0) @(posedge clock);
      repeat (BANK_LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input int unsigned value);
      csr_write <= 1'b1;
      csr_addr  <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      case (idx)
         CSR_PERIOD_TICKS:    cfg_period      = TICK_W'(value);
         CSR_MIN_PULSE:       cfg_min_pulse   = TICK_W'(value);
         CSR_MAX_PULSE:       cfg_max_pulse   = TICK_W'(value);
         CSR_ACTIVE_CHANNELS: cfg_servo_count = COUNT_W'(value);
         default: ;
      endcase
   endtask

   // Reprograms every register once the bank has gone idle.
   task automatic set_bank(input int unsigned period, input int unsigned min_p,
                           input int unsigned max_p, input int unsigned count);
      drain_bank();
      write_csr(CSR_PERIOD_TICKS, period);
      write_csr(CSR_MIN_PULSE, min_p);
      write_csr(CSR_MAX_PULSE, max_p);
      write_csr(CSR_ACTIVE_CHANNELS, count);
      csr_write <= 1'b0;
   endtask

   // Response sink: random stalls, or a long hold-off when one is requested.
   initial begin : rsp_sink
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= $urandom_range(99) >= receiver_idle_pct;
         end
      end
   end

   // Each response beat is compared with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (servo_rsp_q.size() == 0) begin
            $error("unexpected response beat %h", rsp_payload);
            error_count++;
         end else begin
            want = servo_rsp_q.pop_front();
            if (rsp_payload.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_payload.ok);
               error_count++;
            end
            if (rsp_payload.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value,
                      rsp_payload.read_value);
               error_count++;
            end
            if (rsp_payload.pwm_levels !== want.pwm_levels) begin
               $error("pwm_levels: expected %b, got %b", want.pwm_levels,
                      rsp_payload.pwm_levels);
               error_count++;
            end
            if (rsp_payload.period_start !== want.period_start) begin
               $error("period_start: expected %0d, got %0d", want.period_start,
                      rsp_payload.period_start);
               error_count++;
            end
         end
      end
   end

   // Default settings: every kind, bad channels, rejected and accepted pulses.
   task automatic test_directed_items();
      send_item(make_item(KIND_READ, 1, 0));
      send_item(make_item(KIND_READ, 0, 0));
      send_item(make_item(KIND_READ, 15, 65535));
      send_item(make_item(KIND_WRITE, 1, 1000));
      send_item(make_item(KIND_WRITE, 8, 2000));
      send_item(make_item(KIND_WRITE, 2, 999));
      send_item(make_item(KIND_WRITE, 3, 2001));
      send_item(make_item(KIND_WRITE, 4, 65535));
      send_item(make_item(KIND_WRITE, 0, 1500));
      send_item(make_item(KIND_WRITE, 9, 1500));
      send_item(make_item(KIND_WRITE, 15, 1500));
      send_item(make_item(KIND_WRITE, 5, 0));
      send_item(make_item(KIND_WRITE, 6, 1500));
      send_item(make_item(KIND_TICK, 15, 65535));
      send_item(make_item(KIND_TICK, 0, 0));
      send_item(make_item(KIND_TICK, 7, 12345));
      send_item(make_item(KIND_UNUSED, 15, 65535));
      send_item(make_item(KIND_UNUSED, 1, 0));
      send_item(make_item(KIND_READ, 8, 0));
      send_item(make_item(KIND_READ, 6, 0));
      send_item(make_item(KIND_WRITE, 1, 0));
      send_item(make_item(KIND_READ, 1, 0));
      send_item(make_item(KIND_WRITE, 7, 1000));
      send_item(make_item(KIND_READ, 7, 0));
   endtask

   // Register extremes: short and zero periods, every servo count, min above max.
   task automatic test_bank_settings();
      set_bank(3, 1, 65535, 8);
      for (int unsigned ch = 1; ch <= NUM_CH; ch++)
         send_item(make_item(KIND_WRITE, ch, ch));
      repeat (10) send_item(make_item(KIND_TICK, 0, 0));
      for (int unsigned n = 0; n < 16; n++) begin
         set_bank(3, 1, 65535, n);
         repeat (5) send_item(make_item(KIND_TICK, n, 0));
      end
      set_bank(0, 1, 65535, 8);
      repeat (3) send_item(make_item(KIND_TICK, 0, 0));
      set_bank(0, 50, 10, 8);
      send_item(make_item(KIND_WRITE, 2, 0));
      send_item(make_item(KIND_WRITE, 3, 30));
      send_item(make_item(KIND_WRITE, 3, 50));
      send_item(make_item(KIND_WRITE, 3, 10));
      set_bank(65535, 65535, 65535, 8);
      send_item(make_item(KIND_WRITE, 4, 65535));
      send_item(make_item(KIND_WRITE, 4, 65534));
      repeat (8) send_item(make_item(KIND_TICK, 0, 0));
      // Lowering the period under the running count wraps on the next tick.
      set_bank(2, 1, 65535, 8);
      repeat (4) send_item(make_item(KIND_TICK, 0, 0));
   endtask

   // Random traffic in blocks, each block under freshly drawn settings.
   task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
      int unsigned period, min_p, max_p, count;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      for (int unsigned b = 0; b < BLOCKS; b++) begin
         case ($urandom_range(9))
            0:       period = 0;
            1:       period = 65535;
            default: period = $urandom_range(48, 1);
         endcase
         min_p = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
         max_p = ($urandom_range(9) == 0) ? 65535 : $urandom_range(64, 1);
         count = ($urandom_range(1) == 0) ? 8 : $urandom_range(15, 0);
         set_bank(period, min_p, max_p, count);
         repeat (BLOCK_ITEMS) send_item(random_item());
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(35, 71);
      run_random_phase(71, 35);
      run_random_phase(0, 0);
   endtask

   // The sink holds off for a long stretch while beats keep coming.
   task automatic test_backpressure();
      set_bank(20, 1, 30, 8);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_request      = HOLD_CYCLES;
      repeat (60) send_item(random_item());
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_addr    = '0;
      csr_data    = '0;
      cfg_period      = PERIOD_TICKS_RESET;
      cfg_min_pulse   = MIN_PULSE_RESET;
      cfg_max_pulse   = MAX_PULSE_RESET;
      cfg_servo_count = ACTIVE_CHANNELS_RESET;
      frame_count     = '0;
      for (int unsigned i = 0; i < NUM_CH; i++) pulse_mem[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_items();
      test_bank_settings();
      test_random_traffic();
      test_backpressure();

      drain_bank();
      repeat (4 * BANK_LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
design/spcb_pkg.sv
design/servo_pwm_channel_bank_core.sv
tb/sv/servo_pwm_channel_bank_core_tb.sv
